/* hdl/mch_pkg.sv */
// Package for the magnetometer calibration and heading block.
// Holds widths, hard-iron offsets, CORDIC constants and the arctangent table.
`default_nettype none
package mch_pkg;
  localparam int CordicStages = 16;
  localparam int CordicCells = CordicStages + 1;
  localparam int ShiftW = $clog2(CordicStages);
  localparam int NumRegs = 6;
  localparam int CfgIdxW = 3;
  localparam int AxisW = 25;
  localparam int CordW = 36;
  localparam int AngW = 26;

  localparam logic signed [AxisW-1:0] OffX = 25'sd14789;
  localparam logic signed [AxisW-1:0] OffY = 25'sd21120;
  localparam logic signed [AxisW-1:0] OffZ = 25'sd27478;
  localparam logic signed [AngW-1:0] Deg180 = 26'sd11796480;
  localparam logic signed [AngW-1:0] Deg360 = 26'sd23592960;
  localparam logic [16:0] FullQ7 = 17'd46080;

  localparam logic [CfgIdxW-1:0] RegXx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegXz = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYz = 3'd4;
  localparam logic [CfgIdxW-1:0] RegZz = 3'd5;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } axes_t;

  typedef struct packed {
    logic               zero;
    axes_t              cal;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  ang;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        0: r = 26'sd2949120;  1: r = 26'sd1740967; 2: r = 26'sd919879;
        3: r = 26'sd466945;   4: r = 26'sd234379;  5: r = 26'sd117304;
        6: r = 26'sd58666;    7: r = 26'sd29335;   8: r = 26'sd14668;
        9: r = 26'sd7334;     10: r = 26'sd3667;   11: r = 26'sd1833;
        12: r = 26'sd917;     13: r = 26'sd458;    14: r = 26'sd229;
        15: r = 26'sd115;     16: r = 26'sd57;     17: r = 26'sd29;
        18: r = 26'sd14;      19: r = 26'sd7;      20: r = 26'sd4;
        21: r = 26'sd2;       22: r = 26'sd1;      default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* hdl/mch_if.sv */
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on mch_pkg.
`default_nettype none
interface mch_in_if import mch_pkg::*; ();
  logic valid, ready;
  logic signed [15:0] raw_x, raw_y, raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface mch_out_if import mch_pkg::*; ();
  logic valid, ready;
  logic signed [15:0] cal_x, cal_y, cal_z;
  logic [15:0] heading;
  modport source (output valid, cal_x, cal_y, cal_z, heading, input ready);
  modport sink (input valid, cal_x, cal_y, cal_z, heading, output ready);
endinterface

interface mch_cfg_if import mch_pkg::*; ();
  logic valid, ready;
  logic [CfgIdxW-1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/mch_cell.sv */
// One vectoring CORDIC cell: a micro-rotation and a register stage.
// Depends on mch_pkg; the shift and the arctangent step are tied to constants.
`default_nettype none
module mch_cell import mch_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [ShiftW-1:0]      shamt,
  input  wire logic signed [AngW-1:0] rot_ang,
  input  wire cord_t                  d,
  output cord_t                       q
);
  logic signed [CordW-1:0] xs, ys;
  cord_t n;
  assign xs = d.x >>> shamt;
  assign ys = d.y >>> shamt;
  always_comb begin
    n = d;
    if (!d.y[CordW-1]) begin
      n.x = d.x + ys;
      n.y = d.y - xs;
      n.ang = d.ang + rot_ang;
    end else begin
      n.x = d.x - ys;
      n.y = d.y + xs;
      n.ang = d.ang - rot_ang;
    end
  end
  always_ff @(posedge clk) begin
    if (en) q <= n;
  end
endmodule
`default_nettype wire

/* hdl/magnetometer_calibrate_heading.sv */
// Magnetometer calibration with heading: hard/soft-iron correction and CORDIC atan2.
// Throughput one sample per cycle while out.ready is high.
// The whole pipeline advances together and stalls only when the output is held.
// Synchronous active-high reset clears valid bits and loads coefficient reset values.
// Depends on mch_pkg, mch_if and mch_cell.
`default_nettype none
module magnetometer_calibrate_heading import mch_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  mch_in_if.sink   in,
  mch_out_if.source out,
  mch_cfg_if.sink  cfg
);
  localparam int Depth = CordicStages + 4;
  logic signed [15:0] coef [NumRegs];
  logic [Depth-1:0] vld;
  logic adv;

  // The pipeline advances whenever the last stage is empty or being taken.
  assign adv = !vld[Depth-1] || out.ready;
  assign in.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= 16'sd12147; coef[1] <= 16'sd367; coef[2] <= 16'sd858;
      coef[3] <= 16'sd13126; coef[4] <= 16'sd962; coef[5] <= 16'sd10781;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegXx: coef[0] <= cfg.data;
        RegXy: coef[1] <= cfg.data;
        RegXz: coef[2] <= cfg.data;
        RegYy: coef[3] <= cfg.data;
        RegYz: coef[4] <= cfg.data;
        RegZz: coef[5] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in.valid};
  end

  // Stage 1: biased axes in Q.8.
  logic signed [AxisW-1:0] ax, ay, az;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= AxisW'({{9{in.raw_x[15]}}, in.raw_x} <<< 8) + OffX;
      ay <= AxisW'({{9{in.raw_y[15]}}, in.raw_y} <<< 8) + OffY;
      az <= AxisW'({{9{in.raw_z[15]}}, in.raw_z} <<< 8) + OffZ;
    end
  end

  // Stage 2: nine products, each 25x16 bits, registered.
  logic signed [40:0] p [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= coef[0] * ax; p[1] <= coef[1] * ay; p[2] <= coef[2] * az;
      p[3] <= coef[1] * ax; p[4] <= coef[3] * ay; p[5] <= coef[4] * az;
      p[6] <= coef[2] * ax; p[7] <= coef[4] * ay; p[8] <= coef[5] * az;
    end
  end

  function automatic logic signed [15:0] trunc_sat(input logic signed [42:0] v);
    logic [42:0] m;
    logic signed [42:0] q;
    begin
      m = v[42] ? 43'(-v) : 43'(v);
      m = m >> 20;
      q = v[42] ? 43'(-$signed(m)) : $signed(m);
      if (q > 43'sd32767) return 16'sd32767;
      else if (q < -43'sd32768) return -16'sd32768;
      else return q[15:0];
    end
  endfunction

  // Stage 3: sums, truncation and saturation; CORDIC set-up.
  cord_t c [CordicCells];
  cord_t c_init;
  axes_t cal;
  logic signed [42:0] sx, sy, sz;
  assign sx = 43'(p[0]) + 43'(p[1]) + 43'(p[2]);
  assign sy = 43'(p[3]) + 43'(p[4]) + 43'(p[5]);
  assign sz = 43'(p[6]) + 43'(p[7]) + 43'(p[8]);
  always_comb begin
    cal.cx = trunc_sat(sx);
    cal.cy = trunc_sat(sy);
    cal.cz = trunc_sat(sz);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_init.cal <= cal;
      c_init.zero <= (cal.cy == 16'sd0) && (cal.cz == 16'sd0);
      if (cal.cy[15]) begin
        c_init.x <= -(CordW'(cal.cy) <<< 16);
        c_init.y <= -(CordW'(cal.cz) <<< 16);
        c_init.ang <= Deg180;
      end else begin
        c_init.x <= CordW'(cal.cy) <<< 16;
        c_init.y <= CordW'(cal.cz) <<< 16;
        c_init.ang <= '0;
      end
    end
  end
  assign c[0] = c_init;

  // Row of CORDIC cells, one micro-rotation each; cell g shifts by g.
  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    mch_cell u_cell (
      .clk(clk), .en(adv), .shamt(ShiftW'(g)), .rot_ang(atan_entry(g)),
      .d(c[g]), .q(c[g+1])
    );
  end

  // Final stage: wrap into 0..360 degrees and round to Q9.7.
  cord_t f;
  logic signed [AngW-1:0] a1;
  logic [AngW-1:0] a2;
  logic [16:0] hq;
  assign f = c[CordicStages];
  always_comb begin
    a1 = f.ang;
    if (a1 < 0) a1 = a1 + Deg360;
    if (a1 >= Deg360) a1 = a1 - Deg360;
    a2 = AngW'(a1) + AngW'(256);
    hq = a2[25:9];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out.cal_x <= f.cal.cx;
      out.cal_y <= f.cal.cy;
      out.cal_z <= f.cal.cz;
      out.heading <= (f.zero || hq >= FullQ7) ? 16'd0 : hq[15:0];
    end
  end
  assign out.valid = vld[Depth-1];

  // A result held under back-pressure keeps its heading and cal_y.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> $stable(out.heading) && $stable(out.cal_y))
    else $error("held result changed");
  // Heading never reaches 360 degrees.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.heading < 16'd46080)
    else $error("heading out of range");
  // A zero vector gives a zero heading.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.cal_y == 16'sd0 && out.cal_z == 16'sd0 |-> out.heading == 16'd0)
    else $error("zero vector heading");
endmodule
`default_nettype wire
